[hw/rtl/vector_similarity_engine_assert.svh]
// Assertion macros shared by the RTL of the vector similarity engine.
// Each macro expects signals named clk and rst in the enclosing module.
`ifndef VECTOR_SIMILARITY_ENGINE_ASSERT_SVH
`define VECTOR_SIMILARITY_ENGINE_ASSERT_SVH

// Same-cycle implication.
`define VSE_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("vector_similarity_engine: same-cycle check failed");

// Next-cycle implication.
`define VSE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("vector_similarity_engine: next-cycle check failed");

`endif

[hw/rtl/vse_pkg.sv]
`timescale 1ns / 1ps

package vse_pkg;

  localparam int ELEM_W     = 16;
  localparam int MAX_LEN    = 4096;
  localparam int CNT_W      = $clog2(MAX_LEN + 1);
  localparam int MAIN_W     = 46;
  localparam int NORM_W     = 43;
  localparam int OUT_W      = 44;
  localparam int MUL_W      = 23;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ROOT_W     = 22;
  localparam int DEN_W      = 44;
  localparam int FRAC_W     = 15;
  localparam int DIVN_W     = MAIN_W + FRAC_W;
  localparam int REM_W      = DEN_W;
  localparam int SUB_W      = MAIN_W + 1;
  localparam int Q_W        = 17;
  localparam int SQRT_STEPS = MAIN_W / 2;
  localparam int DIV_STEPS  = DIVN_W;
  localparam int STEP_W     = 6;
  localparam int ADDR_W     = 3;
  localparam int DATA_W     = 32;

  localparam logic [ADDR_W-3:0] REG_METRIC_MODE = 1'b0;

  typedef enum logic [1:0] {
    MODE_L1     = 2'd0,
    MODE_L2     = 2'd1,
    MODE_DOT    = 2'd2,
    MODE_COSINE = 2'd3
  } metric_mode_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_MAIN,
    ST_MUL_NA,
    ST_MUL_NB,
    ST_ADD_NB,
    ST_FIN,
    ST_SQRT_L2,
    ST_SQRT_A,
    ST_SQRT_B,
    ST_DEN,
    ST_DIV_INIT,
    ST_DIV,
    ST_COS,
    ST_DONE
  } state_t;

endpackage

[hw/rtl/vector_similarity_engine.sv]
`timescale 1ns / 1ps

// Vector similarity engine: L1, L2, dot product or cosine over paired elements.
// Input channel: elem_a, elem_b and last_elem move on a transfer (in_valid high
// and in_stall low). For each pair, one shared 23x23 multiplier and one
// accumulate adder produce the metric term and both squared norms in turn.
// Pairs past the length limit are dropped and set too_long.
// After the pair marked last_elem, L1 and dot product give the accumulated sum;
// L2 adds a square root of 23 steps, and cosine two 23-step square roots,
// one multiply and 61 divide steps; the square roots and the divide share
// one compare-subtract unit. The block is stalled meanwhile.
// Output channel: metric_value, zero_norm and too_long sit in an output
// register; the block goes on taking pairs while a result waits under
// out_stall, and only holds at its next result until that one is taken.
// metric_mode is to be written over the APB port only while the block is idle;
// the block itself does not enforce this. Reset (rst, synchronous) clears the
// accumulators and the output valid and sets metric_mode to L1.
module vector_similarity_engine
  import vse_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [ELEM_W-1:0]  elem_a,
  input  logic signed [ELEM_W-1:0]  elem_b,
  input  logic                      last_elem,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   metric_value,
  output logic                      zero_norm,
  output logic                      too_long
);

  localparam logic signed [MAIN_W-1:0] MAIN_MAX = {1'b0, {(MAIN_W-1){1'b1}}};
  localparam logic signed [MAIN_W-1:0] MAIN_MIN = {1'b1, {(MAIN_W-1){1'b0}}};
  localparam logic [NORM_W-1:0]        NORM_MAX = {NORM_W{1'b1}};
  localparam logic signed [MAIN_W-1:0] OUT_LIM  = {4'b0001, {(MAIN_W-4){1'b0}}};
  localparam logic signed [MAIN_W-1:0] COS_MAX  = 46'sd32767;
  localparam logic signed [MAIN_W-1:0] COS_MIN  = -46'sd32768;
  localparam logic [Q_W-1:0]           Q_POS_MAX = 17'd32767;
  localparam logic [Q_W-1:0]           Q_NEG_MAX = 17'd32768;
  localparam logic [MAIN_W-1:0]        SQ_BIT0  = {2'b01, {(MAIN_W-2){1'b0}}};
  localparam logic [STEP_W-1:0]        SQRT_LAST = STEP_W'(SQRT_STEPS - 1);
  localparam logic [STEP_W-1:0]        DIV_LAST  = STEP_W'(DIV_STEPS - 1);

  state_t                     state, state_next;
  metric_mode_t               metric_mode;

  logic signed [ELEM_W-1:0]   a_q, b_q;
  logic                       last_q;
  logic signed [MAIN_W-1:0]   main_accum;
  logic [NORM_W-1:0]          norm_a_accum, norm_b_accum;
  logic [CNT_W-1:0]           elem_count;
  logic                       overflow_seen;
  logic signed [PROD_W-1:0]   prod;

  logic [MAIN_W-1:0]          sq_x, sq_res, sq_bit;
  logic [ROOT_W-1:0]          root_a;
  logic [DEN_W-1:0]           den;
  logic [REM_W-1:0]           rem;
  logic [DIVN_W-1:0]          div_n;
  logic [Q_W-1:0]             quot;
  logic                       quot_big;
  logic [STEP_W-1:0]          step;
  logic signed [MAIN_W-1:0]   result;
  logic                       zn_flag;

  logic                       in_xfer, room;
  logic                       count_ok;
  logic                       norm_zero;
  logic signed [ELEM_W:0]     diff_ab, abs_ab;
  logic signed [MUL_W-1:0]    mul_x, mul_y;
  logic signed [PROD_W-1:0]   product;
  logic signed [SUB_W-1:0]    acc_op, acc_sum;
  logic signed [MAIN_W-1:0]   main_sat;
  logic [NORM_W-1:0]          norm_sat;
  logic [SUB_W-1:0]           sub_a, sub_b;
  logic [SUB_W:0]             sub_diff;
  logic                       sub_ge;
  logic [REM_W:0]             rem_sh;
  logic [MAIN_W-1:0]          sq_res_next;
  logic [MAIN_W-1:0]          mag;
  logic signed [MAIN_W-1:0]   clamped;

  // Configuration port.
  assign pready = 1'b1;
  assign prdata = (paddr[ADDR_W-1:2] == REG_METRIC_MODE) ?
                  DATA_W'(metric_mode) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      metric_mode <= MODE_L1;
    end else if (psel && penable && pwrite && pready &&
                 paddr[ADDR_W-1:2] == REG_METRIC_MODE) begin
      metric_mode <= metric_mode_t'(pwdata[1:0]);
    end
  end

  assign in_stall  = (state != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign room      = !out_valid || !out_stall;
  assign count_ok  = elem_count < CNT_W'(MAX_LEN);
  assign norm_zero = (norm_a_accum == '0) || (norm_b_accum == '0);

  // Shared multiplier.
  assign diff_ab = (ELEM_W+1)'(a_q) - (ELEM_W+1)'(b_q);
  assign abs_ab  = diff_ab[ELEM_W] ? -diff_ab : diff_ab;

  always_comb begin
    mul_x = '0;
    mul_y = '0;
    case (state)
      ST_MUL_MAIN: begin
        if (metric_mode == MODE_L2) begin
          mul_x = MUL_W'(diff_ab);
          mul_y = MUL_W'(diff_ab);
        end else begin
          mul_x = MUL_W'(a_q);
          mul_y = MUL_W'(b_q);
        end
      end
      ST_MUL_NA: begin
        mul_x = MUL_W'(a_q);
        mul_y = MUL_W'(a_q);
      end
      ST_MUL_NB: begin
        mul_x = MUL_W'(b_q);
        mul_y = MUL_W'(b_q);
      end
      ST_DEN: begin
        mul_x = {1'b0, root_a};
        mul_y = {1'b0, sq_res[ROOT_W-1:0]};
      end
      default: begin
        mul_x = '0;
        mul_y = '0;
      end
    endcase
  end

  assign product = mul_x * mul_y;

  // Accumulate adder, shared by the metric sum and both norms.
  always_comb begin
    case (state)
      ST_MUL_NA: acc_op = SUB_W'(main_accum);
      ST_MUL_NB: acc_op = SUB_W'({1'b0, norm_a_accum});
      default:   acc_op = SUB_W'({1'b0, norm_b_accum});
    endcase
  end

  assign acc_sum = acc_op + SUB_W'(prod);

  always_comb begin
    if (acc_sum[SUB_W-1] != acc_sum[SUB_W-2]) begin
      main_sat = acc_sum[SUB_W-1] ? MAIN_MIN : MAIN_MAX;
    end else begin
      main_sat = acc_sum[MAIN_W-1:0];
    end
    if (acc_sum[SUB_W-1:NORM_W] != '0) begin
      norm_sat = NORM_MAX;
    end else begin
      norm_sat = acc_sum[NORM_W-1:0];
    end
  end

  // Shared compare-subtract unit for square root and division steps.
  assign rem_sh = {rem, div_n[DIVN_W-1]};

  always_comb begin
    if (state == ST_DIV) begin
      sub_a = SUB_W'(rem_sh);
      sub_b = SUB_W'(den);
    end else begin
      sub_a = SUB_W'(sq_x);
      sub_b = SUB_W'(sq_res | sq_bit);
    end
  end

  assign sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge   = !sub_diff[SUB_W];

  assign sq_res_next = sub_ge ? ((sq_res >> 1) | sq_bit) : (sq_res >> 1);
  assign mag = main_accum[MAIN_W-1] ? MAIN_W'(-main_accum) : MAIN_W'(main_accum);

  always_comb begin
    if (result > OUT_LIM) begin
      clamped = OUT_LIM;
    end else if (result < -OUT_LIM) begin
      clamped = -OUT_LIM;
    end else begin
      clamped = result;
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (count_ok) begin
            state_next = ST_MUL_MAIN;
          end else if (last_elem) begin
            state_next = ST_FIN;
          end
        end
      end
      ST_MUL_MAIN: state_next = ST_MUL_NA;
      ST_MUL_NA:   state_next = ST_MUL_NB;
      ST_MUL_NB:   state_next = ST_ADD_NB;
      ST_ADD_NB:   state_next = last_q ? ST_FIN : ST_IDLE;
      ST_FIN: begin
        unique case (metric_mode)
          MODE_L2:     state_next = ST_SQRT_L2;
          MODE_COSINE: state_next = norm_zero ? ST_DONE : ST_SQRT_A;
          default:     state_next = ST_DONE;
        endcase
      end
      ST_SQRT_L2:  if (step == '0) state_next = ST_DONE;
      ST_SQRT_A:   if (step == '0) state_next = ST_SQRT_B;
      ST_SQRT_B:   if (step == '0) state_next = ST_DEN;
      ST_DEN:      state_next = ST_DIV_INIT;
      ST_DIV_INIT: state_next = ST_DIV;
      ST_DIV:      if (step == '0) state_next = ST_COS;
      ST_COS:      state_next = ST_DONE;
      ST_DONE:     if (room) state_next = ST_IDLE;
      default:     state_next = ST_IDLE;
    endcase
  end

  // Accumulators and counters.
  always_ff @(posedge clk) begin
    if (rst) begin
      main_accum    <= '0;
      norm_a_accum  <= '0;
      norm_b_accum  <= '0;
      elem_count    <= '0;
      overflow_seen <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (in_xfer && !count_ok) begin
            overflow_seen <= 1'b1;
          end
        end
        ST_MUL_MAIN: elem_count   <= elem_count + 1'b1;
        ST_MUL_NA:   main_accum   <= main_sat;
        ST_MUL_NB:   norm_a_accum <= norm_sat;
        ST_ADD_NB:   norm_b_accum <= norm_sat;
        ST_DONE: begin
          if (room) begin
            main_accum    <= '0;
            norm_a_accum  <= '0;
            norm_b_accum  <= '0;
            elem_count    <= '0;
            overflow_seen <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath registers of the shared units.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          a_q    <= elem_a;
          b_q    <= elem_b;
          last_q <= last_elem;
        end
      end
      ST_MUL_MAIN: begin
        prod <= (metric_mode == MODE_L1) ? PROD_W'(abs_ab) : product;
      end
      ST_MUL_NA, ST_MUL_NB: prod <= product;
      ST_FIN: begin
        zn_flag <= 1'b0;
        result  <= main_accum;
        sq_res  <= '0;
        sq_bit  <= SQ_BIT0;
        step    <= SQRT_LAST;
        if (metric_mode == MODE_L2) begin
          sq_x <= main_accum[MAIN_W-1] ? '0 : MAIN_W'(main_accum);
        end else begin
          sq_x <= MAIN_W'(norm_a_accum);
        end
        if (metric_mode == MODE_COSINE && norm_zero) begin
          zn_flag <= 1'b1;
          result  <= '0;
        end
      end
      ST_SQRT_L2, ST_SQRT_A, ST_SQRT_B: begin
        if (sub_ge) begin
          sq_x <= sub_diff[MAIN_W-1:0];
        end
        sq_res <= sq_res_next;
        sq_bit <= sq_bit >> 2;
        step   <= step - 1'b1;
        if (step == '0) begin
          if (state == ST_SQRT_L2) begin
            result <= MAIN_W'(sq_res_next);
          end else if (state == ST_SQRT_A) begin
            root_a <= sq_res_next[ROOT_W-1:0];
            sq_x   <= MAIN_W'(norm_b_accum);
            sq_res <= '0;
            sq_bit <= SQ_BIT0;
            step   <= SQRT_LAST;
          end
        end
      end
      ST_DEN: prod <= product;
      ST_DIV_INIT: begin
        den      <= prod[DEN_W-1:0];
        rem      <= '0;
        div_n    <= {mag, {FRAC_W{1'b0}}};
        quot     <= '0;
        quot_big <= 1'b0;
        step     <= DIV_LAST;
      end
      ST_DIV: begin
        rem      <= sub_ge ? sub_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
        div_n    <= div_n << 1;
        quot     <= {quot[Q_W-2:0], sub_ge};
        quot_big <= quot_big | quot[Q_W-1];
        step     <= step - 1'b1;
      end
      ST_COS: begin
        if (main_accum[MAIN_W-1]) begin
          result <= (quot_big || quot > Q_NEG_MAX) ? COS_MIN : -MAIN_W'(quot);
        end else begin
          result <= (quot_big || quot > Q_POS_MAX) ? COS_MAX : MAIN_W'(quot);
        end
      end
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_DONE && room) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DONE && room) begin
      metric_value <= clamped[OUT_W-1:0];
      zero_norm    <= zn_flag;
      too_long     <= overflow_seen;
    end
  end

  `include "vector_similarity_engine_assert.svh"

  `VSE_ASSERT_IMPLIES(a_count_range, 1'b1, elem_count <= CNT_W'(MAX_LEN))
  `VSE_ASSERT_IMPLIES(a_div_rem_below_den, state == ST_DIV, rem < den)
  `VSE_ASSERT_IMPLIES(a_fin_after_last, state == ST_FIN, last_q)
  `VSE_ASSERT_NEXT(a_done_loads_output, state == ST_DONE && room, out_valid && state == ST_IDLE)

endmodule
